[hw/rtl/fltw_pkg.sv]
// shared types, constants and helpers for the four-level page table walker
// no dependencies; used by every module of the walker

package fltw_pkg;

  // input item modes
  localparam logic MODE_TRANSLATE = 1'b0;
  localparam logic MODE_RESPONSE  = 1'b1;

  // result kinds
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  // page size codes
  localparam logic [1:0] PAGE_NONE = 2'd0;
  localparam logic [1:0] PAGE_4K   = 2'd1;
  localparam logic [1:0] PAGE_2M   = 2'd2;
  localparam logic [1:0] PAGE_1G   = 2'd3;

  // walk levels
  localparam logic [1:0] LEVEL_PML4 = 2'd0;
  localparam logic [1:0] LEVEL_PDPT = 2'd1;
  localparam logic [1:0] LEVEL_PD   = 2'd2;
  localparam logic [1:0] LEVEL_PT   = 2'd3;

  // entry bits
  localparam int PRESENT_BIT   = 0;
  localparam int PAGE_SIZE_BIT = 7;

  // fallback direct-map base
  localparam logic [63:0] FIXED_DMAP = 64'hFFFF_873B_0000_0000;

  // configuration register indexes (selected by paddr[3])
  localparam logic REG_ROOT_VIRTUAL  = 1'b0;
  localparam logic REG_ROOT_PHYSICAL = 1'b1;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_NOT_PRESENT = 3'd1,
    STATUS_READ_ERROR  = 3'd2,
    STATUS_NO_ROOT     = 3'd3,
    STATUS_UNEXPECTED  = 3'd4
  } status_t;

  typedef struct packed {
    logic        busy;
    logic [1:0]  level;
    logic [47:0] saved_address;
  } walk_state_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] read_address;
    logic [51:0] physical_address;
    logic [1:0]  page_size_code;
    status_t     status;
  } result_t;

  // nine-bit table index of a virtual address at a given level
  function automatic logic [8:0] table_index(input logic [47:0] va, input logic [1:0] level);
    logic [8:0] idx;
    case (level)
      LEVEL_PML4: idx = va[47:39];
      LEVEL_PDPT: idx = va[38:30];
      LEVEL_PD:   idx = va[29:21];
      LEVEL_PT:   idx = va[20:12];
      default:    idx = va[47:39];
    endcase
    return idx;
  endfunction

endpackage

[hw/rtl/fltw_step.sv]
// combinational walk step: one input item against the current walk state
// depends on fltw_pkg

module fltw_step (
  input  logic                 mode,
  input  logic [47:0]          virtual_address,
  input  logic [63:0]          read_data,
  input  logic                 read_ok,
  input  fltw_pkg::walk_state_t cur,
  input  logic [63:0]          root_virtual,
  input  logic [63:0]          root_physical,
  input  logic [63:0]          dmap_value,
  output fltw_pkg::walk_state_t nxt,
  output fltw_pkg::result_t    res,
  output logic [63:0]          dmap_derived
);

  logic [64:0] root_diff;
  logic        dmap_usable;
  logic [63:0] root_addr;
  logic [1:0]  next_level;
  logic [63:0] next_addr;
  logic        no_root;

  // direct-map base from the two root registers, else the fixed base
  assign root_diff    = {1'b0, root_virtual} - {1'b0, root_physical};
  assign dmap_usable  = !root_diff[64] && (root_physical[63:40] == 24'd0)
                        && (root_diff[63:48] != 16'd0);
  assign dmap_derived = dmap_usable ? root_diff[63:0] : fltw_pkg::FIXED_DMAP;

  // first entry address comes from the new virtual address
  assign root_addr = root_virtual
                     + {52'd0, fltw_pkg::table_index(virtual_address,
                                                     fltw_pkg::LEVEL_PML4), 3'b000};

  // next entry address: masked table base and index never overlap, so one add
  assign next_level = cur.level + 2'd1;
  assign next_addr  = dmap_value
                      + {12'd0, read_data[51:12],
                         fltw_pkg::table_index(cur.saved_address, next_level), 3'b000};

  assign no_root = (root_virtual == 64'd0) || (root_physical == 64'd0);

  always_comb begin
    nxt                  = cur;
    res.kind             = fltw_pkg::KIND_DONE;
    res.read_address     = 64'd0;
    res.physical_address = 52'd0;
    res.page_size_code   = fltw_pkg::PAGE_NONE;
    res.status           = fltw_pkg::STATUS_OK;

    if (mode == fltw_pkg::MODE_TRANSLATE) begin
      // start of a walk, dropping any walk in progress
      nxt.level = fltw_pkg::LEVEL_PML4;
      if (no_root) begin
        nxt.busy   = 1'b0;
        res.status = fltw_pkg::STATUS_NO_ROOT;
      end else begin
        nxt.busy          = 1'b1;
        nxt.saved_address = virtual_address;
        if (root_addr == 64'd0) begin
          nxt.busy   = 1'b0;
          res.status = fltw_pkg::STATUS_READ_ERROR;
        end else begin
          res.kind         = fltw_pkg::KIND_REQUEST;
          res.read_address = root_addr;
        end
      end
    end else if (!cur.busy) begin
      // response with no walk in progress
      res.status = fltw_pkg::STATUS_UNEXPECTED;
    end else if (!read_ok) begin
      nxt.busy   = 1'b0;
      res.status = fltw_pkg::STATUS_READ_ERROR;
    end else if (!read_data[fltw_pkg::PRESENT_BIT]) begin
      nxt.busy   = 1'b0;
      res.status = fltw_pkg::STATUS_NOT_PRESENT;
    end else if (cur.level == fltw_pkg::LEVEL_PDPT && read_data[fltw_pkg::PAGE_SIZE_BIT]) begin
      // 1G page
      nxt.busy             = 1'b0;
      res.physical_address = {read_data[51:30], cur.saved_address[29:0]};
      res.page_size_code   = fltw_pkg::PAGE_1G;
    end else if (cur.level == fltw_pkg::LEVEL_PD && read_data[fltw_pkg::PAGE_SIZE_BIT]) begin
      // 2M page
      nxt.busy             = 1'b0;
      res.physical_address = {read_data[51:21], cur.saved_address[20:0]};
      res.page_size_code   = fltw_pkg::PAGE_2M;
    end else if (cur.level == fltw_pkg::LEVEL_PT) begin
      // 4K page
      nxt.busy             = 1'b0;
      res.physical_address = {read_data[51:12], cur.saved_address[11:0]};
      res.page_size_code   = fltw_pkg::PAGE_4K;
    end else begin
      // descend one level
      nxt.level = next_level;
      if (next_addr == 64'd0) begin
        nxt.busy   = 1'b0;
        res.status = fltw_pkg::STATUS_READ_ERROR;
      end else begin
        res.kind         = fltw_pkg::KIND_REQUEST;
        res.read_address = next_addr;
      end
    end
  end

endmodule

[hw/rtl/fltw_outbuf.sv]
// output register with one skid entry for walker results
// depends on fltw_pkg

module fltw_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fltw_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output fltw_pkg::result_t out_data
);

  logic              skid_valid;
  fltw_pkg::result_t skid_data;
  logic              take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  // control: output slot and skid slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // payload moves
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

[hw/rtl/four_level_page_table_walker.sv]
// Four-level page table walker. Each input item is either a translate request
// or a memory read response; each gives exactly one result, either the next
// entry address to read or the end of the walk with a status. An item's result
// is registered in the output register or, if stalled, its skid entry, so one
// item per cycle is sustained while out_stall is low; in_stall rises only when
// the output register and its skid entry both hold results not yet transferred.
// The direct-map base is captured from the root registers on the first walk after
// reset with both roots set and kept until reset. Registers lie at byte 0 (root
// virtual) and byte 8 (root physical); write them only while no walk is open.
//
// top level: depends on fltw_pkg, fltw_step and fltw_outbuf

module four_level_page_table_walker (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [47:0] virtual_address,
  input  logic [63:0] read_data,
  input  logic        read_ok,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [63:0] read_address,
  output logic [51:0] physical_address,
  output logic [1:0]  page_size_code,
  output logic [2:0]  status,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]           root_virtual;
  logic [63:0]           root_physical;
  logic                  dmap_known;
  logic [63:0]           dmap_value;
  fltw_pkg::walk_state_t walk;
  fltw_pkg::walk_state_t walk_next;
  fltw_pkg::result_t     step_res;
  fltw_pkg::result_t     out_res;
  logic [63:0]           dmap_derived;
  logic                  accept;
  logic                  cfg_write;
  logic                  buf_full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_virtual  <= 64'd0;
      root_physical <= 64'd0;
    end else if (cfg_write) begin
      if (paddr[3] == fltw_pkg::REG_ROOT_VIRTUAL) begin
        root_virtual <= pwdata;
      end else begin
        root_physical <= pwdata;
      end
    end
  end

  // register read back
  assign prdata = (paddr[3] == fltw_pkg::REG_ROOT_VIRTUAL) ? root_virtual : root_physical;

  fltw_step u_step (
    .mode            (mode),
    .virtual_address (virtual_address),
    .read_data       (read_data),
    .read_ok         (read_ok),
    .cur             (walk),
    .root_virtual    (root_virtual),
    .root_physical   (root_physical),
    .dmap_value      (dmap_value),
    .nxt             (walk_next),
    .res             (step_res),
    .dmap_derived    (dmap_derived)
  );

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (accept) begin
      walk <= walk_next;
    end
  end

  // direct-map base, captured once on the first walk that has both roots
  always_ff @(posedge clk) begin
    if (rst) begin
      dmap_known <= 1'b0;
    end else if (accept && mode == fltw_pkg::MODE_TRANSLATE && !dmap_known
                 && root_virtual != 64'd0 && root_physical != 64'd0) begin
      dmap_known <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode == fltw_pkg::MODE_TRANSLATE && !dmap_known) begin
      dmap_value <= dmap_derived;
    end
  end

  fltw_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  // result fields
  assign kind             = out_res.kind;
  assign read_address     = out_res.read_address;
  assign physical_address = out_res.physical_address;
  assign page_size_code   = out_res.page_size_code;
  assign status           = out_res.status;

endmodule
